@@ src/miller_rabin_witness_test_core_macros.svh @@
// Assertion macros shared by the RTL files of the Miller-Rabin block.
`ifndef MILLER_RABIN_WITNESS_TEST_CORE_MACROS_SVH
`define MILLER_RABIN_WITNESS_TEST_CORE_MACROS_SVH

// The condition holds in the same cycle as the trigger.
`define MRW_ASSERT_SAME(lbl, trig, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error("assertion failed");

// The condition holds in the cycle after the trigger.
`define MRW_ASSERT_NEXT(lbl, trig, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error("assertion failed");

`endif

@@ src/mrw_pkg.sv @@
package mrw_pkg;

  localparam int DefWidth  = 64;
  localparam int BaseWidth = 64;
  localparam int NumSmall  = 10;

  typedef enum logic [2:0] {
    VERDICT_BELOW_TWO   = 3'd0,
    VERDICT_SMALL_PRIME = 3'd1,
    VERDICT_SMALL_DIV   = 3'd2,
    VERDICT_PASSED      = 3'd3,
    VERDICT_FAILED      = 3'd4
  } verdict_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SMALL,
    S_EVAL,
    S_REDUCE,
    S_SPLIT,
    S_CHKA,
    S_POW,
    S_PMUL,
    S_PSQ,
    S_SQ,
    S_SQW,
    S_FIN
  } state_e;

  // Handshake between the sequencer and the modular multiplier.
  typedef struct packed {
    logic start;
  } mul_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  // The ten primes up to 29.
  function automatic logic [4:0] small_prime(input int unsigned idx);
    logic [4:0] p;
    case (idx)
      0: p = 5'd2;
      1: p = 5'd3;
      2: p = 5'd5;
      3: p = 5'd7;
      4: p = 5'd11;
      5: p = 5'd13;
      6: p = 5'd17;
      7: p = 5'd19;
      8: p = 5'd23;
      9: p = 5'd29;
      default: p = 5'd2;
    endcase
    return p;
  endfunction

endpackage

@@ src/mrw_in_if.sv @@
interface mrw_in_if #(
  parameter int WIDTH = mrw_pkg::DefWidth
);
  logic                          valid;
  logic                          ready;
  logic [WIDTH-1:0]              candidate;
  logic [mrw_pkg::BaseWidth-1:0] witness_base;

  modport source (output valid, output candidate, output witness_base, input ready);
  modport sink (input valid, input candidate, input witness_base, output ready);
endinterface

@@ src/mrw_out_if.sv @@
interface mrw_out_if;
  logic       valid;
  logic       ready;
  logic       probably_prime;
  logic [2:0] decided_by;

  modport source (output valid, output probably_prime, output decided_by, input ready);
  modport sink (input valid, input probably_prime, input decided_by, output ready);
endinterface

@@ src/miller_rabin_witness_test_core.sv @@
// Miller-Rabin witness round: each item carries a candidate n (WIDTH bits) and a 64-bit
// witness base, and yields one verdict with the rule that decided it. Items are handled
// one at a time. Trial division runs by the primes up to 29, then the base is reduced
// mod n, and n-1 is split into d*2^r. After that every modular product runs on one
// shared shift-and-add multiplier. An item needs bits(d)+popcount(d) products for the
// power and up to r-1 squarings, which is at most 2*WIDTH-2 products. A full-width
// candidate therefore takes up to 126 products. Small candidates finish after trial
// division, trivial bases after the split, before any product. A finished result
// waits in an output register while the next item is accepted.
`include "miller_rabin_witness_test_core_macros.svh"

module miller_rabin_witness_test_core #(
  parameter int WIDTH = mrw_pkg::DefWidth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  mrw_in_if.sink      in_if,
  mrw_out_if.source   out_if
);
  import mrw_pkg::*;

  localparam int CW = $clog2(WIDTH);
  localparam int BCW = $clog2(BaseWidth);

  state_e               state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [BCW-1:0]       bcnt_q, bcnt_d;
  logic [CW-1:0]        r_q, r_d;
  logic [CW-1:0]        j_q, j_d;
  logic                 found_q, found_d;
  logic [WIDTH-1:0]     n_q, n_d, nm1_q, nm1_d;
  logic [BaseWidth-1:0] a_q, a_d;
  logic [WIDTH-1:0]     x_q, x_d, d_q, d_d, acc_q, acc_d, sq_q, sq_d;
  logic [4:0]           rem_q [NumSmall];
  logic [4:0]           rem_d [NumSmall];
  logic                 ov_q, ov_d;
  logic                 op_q, op_d;
  verdict_e             ob_q, ob_d;
  logic                 vp_q, vp_d;
  verdict_e             vb_q, vb_d;

  mul_req_t             mreq;
  mul_stat_t            mstat;
  logic [WIDTH-1:0]     mul_a, mul_b, mul_res;
  logic [WIDTH:0]       red;
  logic                 any_eq, any_div;

  mrw_modmul #(.WIDTH(WIDTH)) u_modmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mreq),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .m_i    (n_q),
    .stat_o (mstat),
    .res_o  (mul_res)
  );

  // Small prime equality and divisibility flags from the finished remainders.
  always_comb begin
    any_eq  = 1'b0;
    any_div = 1'b0;
    for (int i = 0; i < NumSmall; i++) begin
      if (n_q == WIDTH'(small_prime(i))) begin
        any_eq = 1'b1;
      end
      if (rem_q[i] == '0) begin
        any_div = 1'b1;
      end
    end
  end

  // One bit of the base enters the running remainder mod n.
  always_comb begin
    red = {x_q, a_q[BaseWidth-1]};
    if (red >= {1'b0, n_q}) begin
      red = red - {1'b0, n_q};
    end
  end

  assign in_if.ready = (state_q == S_IDLE);

  // Sequencer: next state, datapath loads and multiplier requests.
  always_comb begin
    logic [5:0] t;
    state_d    = state_q;
    cnt_d      = cnt_q;
    bcnt_d     = bcnt_q;
    r_d        = r_q;
    j_d        = j_q;
    found_d    = found_q;
    n_d        = n_q;
    nm1_d      = nm1_q;
    a_d        = a_q;
    x_d        = x_q;
    d_d        = d_q;
    acc_d      = acc_q;
    sq_d       = sq_q;
    rem_d      = rem_q;
    vp_d       = vp_q;
    vb_d       = vb_q;
    ov_d       = ov_q;
    op_d       = op_q;
    ob_d       = ob_q;
    mreq.start = 1'b0;
    mul_a      = acc_q;
    mul_b      = sq_q;
    t          = '0;

    if (ov_q && out_if.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_if.valid) begin
          n_d   = in_if.candidate;
          a_d   = in_if.witness_base;
          cnt_d = CW'(WIDTH - 1);
          for (int i = 0; i < NumSmall; i++) begin
            rem_d[i] = '0;
          end
          state_d = S_SMALL;
        end
      end
      // Trial division, one candidate bit per cycle in all ten lanes.
      S_SMALL: begin
        for (int i = 0; i < NumSmall; i++) begin
          t = {rem_q[i], n_q[cnt_q]};
          if (t >= {1'b0, small_prime(i)}) begin
            t = t - {1'b0, small_prime(i)};
          end
          rem_d[i] = t[4:0];
        end
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_EVAL;
        end
      end
      S_EVAL: begin
        nm1_d  = n_q - 1'b1;
        x_d    = '0;
        bcnt_d = BCW'(BaseWidth - 1);
        if (n_q < WIDTH'(2)) begin
          vp_d    = 1'b0;
          vb_d    = VERDICT_BELOW_TWO;
          state_d = S_FIN;
        end else if (any_eq) begin
          vp_d    = 1'b1;
          vb_d    = VERDICT_SMALL_PRIME;
          state_d = S_FIN;
        end else if (any_div) begin
          vp_d    = 1'b0;
          vb_d    = VERDICT_SMALL_DIV;
          state_d = S_FIN;
        end else begin
          state_d = S_REDUCE;
        end
      end
      // Base mod n, one base bit per cycle.
      S_REDUCE: begin
        x_d    = red[WIDTH-1:0];
        a_d    = {a_q[BaseWidth-2:0], 1'b0};
        bcnt_d = bcnt_q - 1'b1;
        if (bcnt_q == '0) begin
          d_d     = nm1_q;
          r_d     = '0;
          state_d = S_SPLIT;
        end
      end
      S_SPLIT: begin
        if (d_q[0]) begin
          state_d = S_CHKA;
        end else begin
          d_d = {1'b0, d_q[WIDTH-1:1]};
          r_d = r_q + 1'b1;
        end
      end
      // Trivial bases pass at once.
      S_CHKA: begin
        if (x_q <= WIDTH'(1) || x_q == nm1_q) begin
          vp_d    = 1'b1;
          vb_d    = VERDICT_PASSED;
          state_d = S_FIN;
        end else begin
          acc_d   = WIDTH'(1);
          sq_d    = x_q;
          state_d = S_POW;
        end
      end
      // Square-and-multiply, exponent bits taken from the low end.
      S_POW: begin
        if (d_q == '0) begin
          found_d = (acc_q == WIDTH'(1)) || (acc_q == nm1_q);
          j_d     = CW'(1);
          state_d = S_SQ;
        end else if (d_q[0]) begin
          mreq.start = 1'b1;
          state_d    = S_PMUL;
        end else begin
          mreq.start = 1'b1;
          mul_a      = sq_q;
          state_d    = S_PSQ;
        end
      end
      S_PMUL: begin
        if (mstat.done) begin
          acc_d      = mul_res;
          mreq.start = 1'b1;
          mul_a      = sq_q;
          state_d    = S_PSQ;
        end
      end
      S_PSQ: begin
        if (mstat.done) begin
          sq_d    = mul_res;
          d_d     = {1'b0, d_q[WIDTH-1:1]};
          state_d = S_POW;
        end
      end
      // Up to r-1 further squarings looking for n-1.
      S_SQ: begin
        if (found_q || j_q >= r_q) begin
          vp_d    = found_q;
          vb_d    = found_q ? VERDICT_PASSED : VERDICT_FAILED;
          state_d = S_FIN;
        end else begin
          mreq.start = 1'b1;
          mul_b      = acc_q;
          state_d    = S_SQW;
        end
      end
      S_SQW: begin
        if (mstat.done) begin
          acc_d   = mul_res;
          found_d = (mul_res == nm1_q);
          j_d     = j_q + 1'b1;
          state_d = S_SQ;
        end
      end
      // Hand the verdict to the output register once it is free.
      S_FIN: begin
        if (!ov_q || out_if.ready) begin
          ov_d    = 1'b1;
          op_d    = vp_q;
          ob_d    = vb_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
      cnt_q   <= '0;
      bcnt_q  <= '0;
      r_q     <= '0;
      j_q     <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
      cnt_q   <= cnt_d;
      bcnt_q  <= bcnt_d;
      r_q     <= r_d;
      j_q     <= j_d;
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q   <= n_d;
    nm1_q <= nm1_d;
    a_q   <= a_d;
    x_q   <= x_d;
    d_q   <= d_d;
    acc_q <= acc_d;
    sq_q  <= sq_d;
    rem_q <= rem_d;
    vp_q  <= vp_d;
    vb_q  <= vb_d;
    op_q  <= op_d;
    ob_q  <= ob_d;
  end

  assign out_if.valid          = ov_q;
  assign out_if.probably_prime = op_q;
  assign out_if.decided_by     = ob_q;

  // An accepted item always starts trial division.
  `MRW_ASSERT_NEXT(a_accept_small, in_if.valid && in_if.ready, state_q == S_SMALL)
  // The multiplier is only started while it is idle.
  `MRW_ASSERT_SAME(a_mul_idle, mreq.start, !mstat.busy)
  // A small prime verdict always says prime, a small divisor verdict composite.
  `MRW_ASSERT_SAME(a_small_verdict, ov_q && ob_q == VERDICT_SMALL_PRIME, op_q)
  `MRW_ASSERT_SAME(a_div_verdict, ov_q && ob_q == VERDICT_SMALL_DIV, !op_q)

endmodule

@@ src/mrw_modmul.sv @@
`include "miller_rabin_witness_test_core_macros.svh"

module mrw_modmul #(
  parameter int WIDTH = mrw_pkg::DefWidth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mrw_pkg::mul_req_t  req_i,
  input  logic [WIDTH-1:0]   a_i,
  input  logic [WIDTH-1:0]   b_i,
  input  logic [WIDTH-1:0]   m_i,
  output mrw_pkg::mul_stat_t stat_o,
  output logic [WIDTH-1:0]   res_o
);
  import mrw_pkg::*;

  localparam int CW = $clog2(WIDTH);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [WIDTH-1:0] a_q, b_q, m_q, acc_q;
  logic [WIDTH-1:0] a_d, b_d, m_d, acc_d;
  logic [WIDTH:0]   dbl, sum;
  logic [WIDTH-1:0] half, step;

  // One shift-and-add step: double mod m, then add a mod m if the bit is set.
  always_comb begin
    dbl = {acc_q, 1'b0};
    if (dbl >= {1'b0, m_q}) begin
      dbl = dbl - {1'b0, m_q};
    end
    half = dbl[WIDTH-1:0];
    sum  = {1'b0, half} + {1'b0, a_q};
    if (sum >= {1'b0, m_q}) begin
      sum = sum - {1'b0, m_q};
    end
    step = b_q[WIDTH-1] ? sum[WIDTH-1:0] : half;
  end

  // Control: load on start, then one multiplier bit per cycle, MSB first.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    b_d    = b_q;
    m_d    = m_q;
    acc_d  = acc_q;
    if (req_i.start && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = CW'(WIDTH - 1);
      a_d    = a_i;
      b_d    = b_i;
      m_d    = m_i;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = step;
      b_d   = {b_q[WIDTH-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    m_q   <= m_d;
    acc_q <= acc_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign res_o       = acc_q;

  // A result is announced only when the unit has just gone idle.
  `MRW_ASSERT_SAME(a_done_idle, done_q, !busy_q)
  // A start while idle always begins a run.
  `MRW_ASSERT_NEXT(a_start_runs, req_i.start && !busy_q, busy_q && cnt_q == CW'(WIDTH - 1))
  // The last step ends the run with a done pulse.
  `MRW_ASSERT_NEXT(a_last_step, busy_q && cnt_q == '0, done_q && !busy_q)

endmodule
